// ===== hw/rtl/fmp_pkg.sv =====
// ----------------------------------------------------------------------------
// fmp_pkg
// shared widths, constants and pipeline payload types of the modulus
// projection datapath
// ----------------------------------------------------------------------------
package fmp_pkg;

    // sample format
    localparam int SAMPLE_WIDTH  = 24;
    localparam int MAG_WIDTH     = SAMPLE_WIDTH - 1;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_WIDTH = ((3 * SAMPLE_WIDTH - 1 + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;

    // square root chain
    localparam int SQ_WIDTH      = 2 * SAMPLE_WIDTH;
    localparam int ROOT_WIDTH    = SAMPLE_WIDTH;
    localparam int REM_WIDTH     = ROOT_WIDTH + 2;

    // division chain
    localparam int PRODU_WIDTH   = SAMPLE_WIDTH + MAG_WIDTH;
    localparam int NUM_WIDTH     = 2 * SAMPLE_WIDTH + 1;
    localparam int QUO_WIDTH     = MAG_WIDTH;
    localparam int PREM_WIDTH    = NUM_WIDTH - QUO_WIDTH;
    localparam int DIVS_WIDTH    = ROOT_WIDTH + 1;

    // blend weight, unsigned Q1.16
    localparam int WEIGHT_WIDTH  = 17;
    localparam int WEIGHT_FRAC   = WEIGHT_WIDTH - 1;
    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_ONE =
        WEIGHT_WIDTH'(64'd1 << WEIGHT_FRAC);

    // blend arithmetic
    localparam int PROD_WIDTH    = SAMPLE_WIDTH + WEIGHT_WIDTH + 1;
    localparam int BLEND_WIDTH   = PROD_WIDTH + 1;
    localparam int RND_WIDTH     = BLEND_WIDTH - WEIGHT_FRAC;
    localparam logic [BLEND_WIDTH-1:0] ROUND_HALF =
        BLEND_WIDTH'(64'd1 << (WEIGHT_FRAC - 1));
    localparam logic [RND_WIDTH-1:0] SAT_NEG_MAG =
        RND_WIDTH'(64'd1 << (SAMPLE_WIDTH - 1));
    localparam logic [RND_WIDTH-1:0] SAT_POS_MAG = SAT_NEG_MAG - RND_WIDTH'(1);
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // per-sample fields that ride along the whole pipeline
    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] re;
        logic [SAMPLE_WIDTH-1:0] im;
        logic [SAMPLE_WIDTH-1:0] are;
        logic [SAMPLE_WIDTH-1:0] aim;
        logic [MAG_WIDTH-1:0]    u;
        logic                    zero;
        logic                    last;
    } side_t;

    // one square root cell's worth of state
    typedef struct packed {
        logic [SQ_WIDTH-1:0]   rad;
        logic [ROOT_WIDTH-1:0] root;
        logic [REM_WIDTH-1:0]  rem;
        side_t                 side;
    } sqrt_state_t;

    // one divider lane: partial remainder, numerator bits then quotient bits
    typedef struct packed {
        logic [PREM_WIDTH-1:0] prem;
        logic [QUO_WIDTH-1:0]  nq;
    } div_lane_t;

    typedef struct packed {
        div_lane_t             re_lane;
        div_lane_t             im_lane;
        logic [DIVS_WIDTH-1:0] divisor;
        side_t                 side;
    } div_state_t;

    // finished result
    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] re;
        logic [SAMPLE_WIDTH-1:0] im;
        logic                    zero;
        logic                    last;
    } res_t;

endpackage

// ===== hw/rtl/fmp_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// fmp_sqrt_cell
// one step of the digit-by-digit square root: two radicand bits in, one root
// bit out
// ----------------------------------------------------------------------------
module fmp_sqrt_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                valid_in,
    input  fmp_pkg::sqrt_state_t state_in,
    output logic                valid_out,
    output fmp_pkg::sqrt_state_t state_out
);

    logic                          valid_reg, valid_next;
    fmp_pkg::sqrt_state_t          state_reg, state_next;
    logic [fmp_pkg::REM_WIDTH-1:0] rem_sh;
    logic [fmp_pkg::REM_WIDTH-1:0] trial;

    always_comb begin
        rem_sh = {state_in.rem[fmp_pkg::REM_WIDTH-3:0],
                  state_in.rad[fmp_pkg::SQ_WIDTH-1 -: 2]};
        trial  = {state_in.root, 2'b01};
        state_next     = state_in;
        state_next.rad = {state_in.rad[fmp_pkg::SQ_WIDTH-3:0], 2'b00};
        if (rem_sh >= trial) begin
            state_next.rem  = rem_sh - trial;
            state_next.root = {state_in.root[fmp_pkg::ROOT_WIDTH-2:0], 1'b1};
        end else begin
            state_next.rem  = rem_sh;
            state_next.root = {state_in.root[fmp_pkg::ROOT_WIDTH-2:0], 1'b0};
        end
        valid_next = en ? valid_in : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;

endmodule

// ===== hw/rtl/fmp_div_cell.sv =====
// ----------------------------------------------------------------------------
// fmp_div_cell
// one restoring division step for the real and imaginary lanes, which share
// the divisor
// ----------------------------------------------------------------------------
module fmp_div_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               valid_in,
    input  fmp_pkg::div_state_t state_in,
    output logic               valid_out,
    output fmp_pkg::div_state_t state_out
);

    logic                valid_reg, valid_next;
    fmp_pkg::div_state_t state_reg, state_next;

    function automatic fmp_pkg::div_lane_t lane_step(
        input fmp_pkg::div_lane_t              lane,
        input logic [fmp_pkg::DIVS_WIDTH-1:0]  d
    );
        logic [fmp_pkg::PREM_WIDTH-1:0] r_sh;
        logic [fmp_pkg::PREM_WIDTH-1:0] d_ext;
        logic                           ge;
        fmp_pkg::div_lane_t             res;
        r_sh  = {lane.prem[fmp_pkg::PREM_WIDTH-2:0], lane.nq[fmp_pkg::QUO_WIDTH-1]};
        d_ext = fmp_pkg::PREM_WIDTH'(d);
        ge    = (r_sh >= d_ext);
        res.prem = ge ? (r_sh - d_ext) : r_sh;
        // quotient bit shifts in where the numerator bit left
        res.nq   = {lane.nq[fmp_pkg::QUO_WIDTH-2:0], ge};
        return res;
    endfunction

    always_comb begin
        state_next         = state_in;
        state_next.re_lane = lane_step(state_in.re_lane, state_in.divisor);
        state_next.im_lane = lane_step(state_in.im_lane, state_in.divisor);
        valid_next         = en ? valid_in : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;

endmodule

// ===== hw/rtl/fmp_blend.sv =====
// ----------------------------------------------------------------------------
// fmp_blend
// picks the projected sample, mixes it with the original by the weight,
// rounds half away from zero and saturates; five register stages
// ----------------------------------------------------------------------------
module fmp_blend (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic [fmp_pkg::WEIGHT_WIDTH-1:0]    weight,
    input  logic                                valid_in,
    input  fmp_pkg::div_state_t                 state_in,
    output logic                                valid_out,
    output fmp_pkg::res_t                       res_out
);

    localparam int W = fmp_pkg::SAMPLE_WIDTH;

    // stage valids: select, multiply, sum, round, saturate
    logic [4:0] vld_reg, vld_next;

    // select stage
    logic [W-1:0] x_re_reg, x_re_next, x_im_reg, x_im_next;
    logic [W-1:0] x2_re_reg, x2_re_next, x2_im_reg, x2_im_next;
    logic [1:0]   x_tag_reg, x_tag_next;

    // multiply stage
    logic [fmp_pkg::WEIGHT_WIDTH-1:0]    wb;
    logic signed [fmp_pkg::PROD_WIDTH-1:0] m_re0_reg, m_re0_next, m_re1_reg, m_re1_next;
    logic signed [fmp_pkg::PROD_WIDTH-1:0] m_im0_reg, m_im0_next, m_im1_reg, m_im1_next;
    logic [1:0] m_tag_reg, m_tag_next;

    // sum stage
    logic signed [fmp_pkg::BLEND_WIDTH-1:0] v_re_reg, v_re_next, v_im_reg, v_im_next;
    logic [1:0] v_tag_reg, v_tag_next;

    // round stage
    logic [fmp_pkg::BLEND_WIDTH-1:0] vu_re, vu_im, rnd_re, rnd_im;
    logic [fmp_pkg::RND_WIDTH-1:0]   r_re_reg, r_re_next, r_im_reg, r_im_next;
    logic                            r_neg_re_reg, r_neg_re_next, r_neg_im_reg, r_neg_im_next;
    logic [1:0]                      r_tag_reg, r_tag_next;

    // saturate stage
    fmp_pkg::res_t res_reg, res_next;

    function automatic logic [W-1:0] saturate(
        input logic [fmp_pkg::RND_WIDTH-1:0] r,
        input logic                          neg
    );
        logic [W-1:0] res;
        if (neg) begin
            res = (r > fmp_pkg::SAT_NEG_MAG) ? fmp_pkg::SAMPLE_MIN
                                             : W'(fmp_pkg::RND_WIDTH'(0) - r);
        end else begin
            res = (r > fmp_pkg::SAT_POS_MAG) ? fmp_pkg::SAMPLE_MAX : W'(r);
        end
        return res;
    endfunction

    always_comb begin
        vld_next = en ? {vld_reg[3:0], valid_in} : vld_reg;

        // projected value, real-axis fallback on zero magnitude
        x_re_next  = state_in.side.re;
        x_im_next  = state_in.side.im;
        x_tag_next = {state_in.side.zero, state_in.side.last};
        if (state_in.side.zero) begin
            x2_re_next = W'(state_in.side.u);
            x2_im_next = '0;
        end else begin
            x2_re_next = state_in.side.re[W-1] ? (W'(0) - W'(state_in.re_lane.nq))
                                               : W'(state_in.re_lane.nq);
            x2_im_next = state_in.side.im[W-1] ? (W'(0) - W'(state_in.im_lane.nq))
                                               : W'(state_in.im_lane.nq);
        end

        wb         = fmp_pkg::WEIGHT_ONE - weight;
        m_re0_next = $signed(x_re_reg)  * $signed({1'b0, wb});
        m_re1_next = $signed(x2_re_reg) * $signed({1'b0, weight});
        m_im0_next = $signed(x_im_reg)  * $signed({1'b0, wb});
        m_im1_next = $signed(x2_im_reg) * $signed({1'b0, weight});
        m_tag_next = x_tag_reg;

        v_re_next  = fmp_pkg::BLEND_WIDTH'(m_re0_reg) + fmp_pkg::BLEND_WIDTH'(m_re1_reg);
        v_im_next  = fmp_pkg::BLEND_WIDTH'(m_im0_reg) + fmp_pkg::BLEND_WIDTH'(m_im1_reg);
        v_tag_next = m_tag_reg;

        // |v| + half in one add: -v = ~v + 1
        vu_re  = v_re_reg;
        vu_im  = v_im_reg;
        r_neg_re_next = vu_re[fmp_pkg::BLEND_WIDTH-1];
        r_neg_im_next = vu_im[fmp_pkg::BLEND_WIDTH-1];
        rnd_re = r_neg_re_next ? (~vu_re + fmp_pkg::ROUND_HALF + fmp_pkg::BLEND_WIDTH'(1))
                               : (vu_re + fmp_pkg::ROUND_HALF);
        rnd_im = r_neg_im_next ? (~vu_im + fmp_pkg::ROUND_HALF + fmp_pkg::BLEND_WIDTH'(1))
                               : (vu_im + fmp_pkg::ROUND_HALF);
        r_re_next  = rnd_re[fmp_pkg::BLEND_WIDTH-1:fmp_pkg::WEIGHT_FRAC];
        r_im_next  = rnd_im[fmp_pkg::BLEND_WIDTH-1:fmp_pkg::WEIGHT_FRAC];
        r_tag_next = v_tag_reg;

        res_next.re   = saturate(r_re_reg, r_neg_re_reg);
        res_next.im   = saturate(r_im_reg, r_neg_im_reg);
        res_next.zero = r_tag_reg[1];
        res_next.last = r_tag_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_re_reg     <= x_re_next;
            x_im_reg     <= x_im_next;
            x2_re_reg    <= x2_re_next;
            x2_im_reg    <= x2_im_next;
            x_tag_reg    <= x_tag_next;
            m_re0_reg    <= m_re0_next;
            m_re1_reg    <= m_re1_next;
            m_im0_reg    <= m_im0_next;
            m_im1_reg    <= m_im1_next;
            m_tag_reg    <= m_tag_next;
            v_re_reg     <= v_re_next;
            v_im_reg     <= v_im_next;
            v_tag_reg    <= v_tag_next;
            r_re_reg     <= r_re_next;
            r_im_reg     <= r_im_next;
            r_neg_re_reg <= r_neg_re_next;
            r_neg_im_reg <= r_neg_im_next;
            r_tag_reg    <= r_tag_next;
            res_reg      <= res_next;
        end
    end

    assign valid_out = vld_reg[4];
    assign res_out   = res_reg;

endmodule

// ===== hw/rtl/fourier_magnitude_projection.sv =====
// ----------------------------------------------------------------------------
// fourier_magnitude_projection
// relaxed Fourier-modulus projection of one complex spectrum sample per cycle
// ----------------------------------------------------------------------------
// The block takes one sample per clock and returns one result per sample, in
// order, when the output side keeps up. The pipeline is built from two chains
// of cells: a square root chain of SAMPLE_WIDTH cells, one root bit each,
// and a divider chain of SAMPLE_WIDTH-1 cells, one quotient bit each for
// both real and imaginary lanes, plus three front stages, two stages between
// the chains and five blend stages. An output register and a skid register
// follow the pipeline; the input keeps taking samples while a result waits
// and stops only when the skid register holds a result too.
// Each sample is rescaled to target_mag with its phase kept (a zero sample
// goes to the positive real axis and raises the zero flag in m_tuser), then
// mixed with the original as (1 - w) * x + w * projected, rounded half away
// from zero and saturated. The weight is written through the cfg channel,
// values above one are taken as one, and it resets to one (full projection).
// Write it only while no samples are in flight.
// ----------------------------------------------------------------------------
module fourier_magnitude_projection (
    input  logic                                aclk,
    input  logic                                aresetn,

    // weight write channel, unsigned Q1.16
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fmp_pkg::WEIGHT_WIDTH-1:0]    cfg_data,

    // input samples
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fmp_pkg::S_TDATA_WIDTH-1:0]   s_tdata,  // real_in, imag_in, target_mag, pad
    input  logic                                s_tlast,  // frame_last

    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fmp_pkg::M_TDATA_WIDTH-1:0]   m_tdata,  // real_out, imag_out
    output logic                                m_tuser,  // zero_norm
    output logic                                m_tlast   // last_out
);

    localparam int W = fmp_pkg::SAMPLE_WIDTH;

    // pipeline advance: the whole pipeline moves unless the skid is occupied
    logic en;

    // relaxation weight, clamped to one on write
    logic [fmp_pkg::WEIGHT_WIDTH-1:0] weight_reg, weight_next;

    // front: unpack, absolute values, zero detect
    logic [W-1:0]               in_re, in_im;
    logic [fmp_pkg::MAG_WIDTH-1:0] in_u;
    logic                       a_valid_reg, a_valid_next;
    fmp_pkg::side_t             a_side_reg, a_side_next;

    // squares
    logic                       b_valid_reg, b_valid_next;
    logic [fmp_pkg::SQ_WIDTH-1:0] b_sq_re_reg, b_sq_re_next, b_sq_im_reg, b_sq_im_next;
    fmp_pkg::side_t             b_side_reg;

    // radicand, head of the square root chain
    logic                       c_valid_reg, c_valid_next;
    fmp_pkg::sqrt_state_t       c_state_reg, c_state_next;

    // square root chain links
    logic [fmp_pkg::ROOT_WIDTH:0] sq_valid;
    fmp_pkg::sqrt_state_t         sq_state [fmp_pkg::ROOT_WIDTH+1];

    // rounded magnitude and the products |x| * target
    logic                           r_valid_reg, r_valid_next;
    logic [fmp_pkg::ROOT_WIDTH-1:0] r_mag_reg, r_mag_next;
    logic [fmp_pkg::PRODU_WIDTH-1:0] r_prod_re_reg, r_prod_re_next;
    logic [fmp_pkg::PRODU_WIDTH-1:0] r_prod_im_reg, r_prod_im_next;
    fmp_pkg::side_t                 r_side_reg;
    fmp_pkg::sqrt_state_t           sq_last;

    // numerators and divisor, head of the divider chain
    logic                          n_valid_reg, n_valid_next;
    fmp_pkg::div_state_t           n_state_reg, n_state_next;
    logic [fmp_pkg::NUM_WIDTH-1:0] num_re, num_im;

    // divider chain links
    logic [fmp_pkg::QUO_WIDTH:0] dv_valid;
    fmp_pkg::div_state_t         dv_state [fmp_pkg::QUO_WIDTH+1];

    // blend output
    logic          bl_valid;
    fmp_pkg::res_t bl_res;

    // output register and skid register
    logic          out_valid_reg, out_valid_next;
    fmp_pkg::res_t out_reg, out_next;
    logic          skid_valid_reg, skid_valid_next;
    fmp_pkg::res_t skid_reg, skid_next;
    logic          out_free;

    assign en        = !skid_valid_reg;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------- weight
    always_comb begin
        weight_next = weight_reg;
        if (cfg_valid) begin
            weight_next = (cfg_data > fmp_pkg::WEIGHT_ONE) ? fmp_pkg::WEIGHT_ONE : cfg_data;
        end
    end

    // ---------------------------------------------------------------- front
    always_comb begin
        in_re = s_tdata[W-1:0];
        in_im = s_tdata[2*W-1:W];
        in_u  = s_tdata[2*W+fmp_pkg::MAG_WIDTH-1:2*W];

        // accepted sample enters only on an enabled edge
        a_valid_next     = en ? s_tvalid : a_valid_reg;
        a_side_next.re   = in_re;
        a_side_next.im   = in_im;
        // -x of the most negative code reads correctly as unsigned
        a_side_next.are  = in_re[W-1] ? (W'(0) - in_re) : in_re;
        a_side_next.aim  = in_im[W-1] ? (W'(0) - in_im) : in_im;
        a_side_next.u    = in_u;
        a_side_next.zero = (in_re == '0) && (in_im == '0);
        a_side_next.last = s_tlast;

        b_valid_next = en ? a_valid_reg : b_valid_reg;
        b_sq_re_next = fmp_pkg::SQ_WIDTH'(a_side_reg.are) * fmp_pkg::SQ_WIDTH'(a_side_reg.are);
        b_sq_im_next = fmp_pkg::SQ_WIDTH'(a_side_reg.aim) * fmp_pkg::SQ_WIDTH'(a_side_reg.aim);

        c_valid_next      = en ? b_valid_reg : c_valid_reg;
        c_state_next.rad  = b_sq_re_reg + b_sq_im_reg;
        c_state_next.root = '0;
        c_state_next.rem  = '0;
        c_state_next.side = b_side_reg;
    end

    // ---------------------------------------------------------------- sqrt chain
    assign sq_valid[0] = c_valid_reg;
    assign sq_state[0] = c_state_reg;

    for (genvar i = 0; i < fmp_pkg::ROOT_WIDTH; i++) begin : g_sqrt
        fmp_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (sq_valid[i]),
            .state_in  (sq_state[i]),
            .valid_out (sq_valid[i+1]),
            .state_out (sq_state[i+1])
        );
    end

    // ---------------------------------------------------------------- between chains
    always_comb begin
        sq_last = sq_state[fmp_pkg::ROOT_WIDTH];

        // round to nearest: up when the remainder exceeds the root
        r_valid_next = en ? sq_valid[fmp_pkg::ROOT_WIDTH] : r_valid_reg;
        r_mag_next   = sq_last.root +
                       fmp_pkg::ROOT_WIDTH'(sq_last.rem > fmp_pkg::REM_WIDTH'(sq_last.root));
        r_prod_re_next = fmp_pkg::PRODU_WIDTH'(sq_last.side.are) *
                         fmp_pkg::PRODU_WIDTH'(sq_last.side.u);
        r_prod_im_next = fmp_pkg::PRODU_WIDTH'(sq_last.side.aim) *
                         fmp_pkg::PRODU_WIDTH'(sq_last.side.u);

        // (2*|x|*u + mag) / (2*mag) rounds half up on the magnitude
        n_valid_next = en ? r_valid_reg : n_valid_reg;
        num_re = fmp_pkg::NUM_WIDTH'({r_prod_re_reg, 1'b0}) + fmp_pkg::NUM_WIDTH'(r_mag_reg);
        num_im = fmp_pkg::NUM_WIDTH'({r_prod_im_reg, 1'b0}) + fmp_pkg::NUM_WIDTH'(r_mag_reg);
        n_state_next.re_lane.prem = num_re[fmp_pkg::NUM_WIDTH-1:fmp_pkg::QUO_WIDTH];
        n_state_next.re_lane.nq   = num_re[fmp_pkg::QUO_WIDTH-1:0];
        n_state_next.im_lane.prem = num_im[fmp_pkg::NUM_WIDTH-1:fmp_pkg::QUO_WIDTH];
        n_state_next.im_lane.nq   = num_im[fmp_pkg::QUO_WIDTH-1:0];
        n_state_next.divisor      = {r_mag_reg, 1'b0};
        n_state_next.side         = r_side_reg;
    end

    // ---------------------------------------------------------------- divider chain
    assign dv_valid[0] = n_valid_reg;
    assign dv_state[0] = n_state_reg;

    for (genvar j = 0; j < fmp_pkg::QUO_WIDTH; j++) begin : g_div
        fmp_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (dv_valid[j]),
            .state_in  (dv_state[j]),
            .valid_out (dv_valid[j+1]),
            .state_out (dv_state[j+1])
        );
    end

    // ---------------------------------------------------------------- blend
    fmp_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .weight    (weight_reg),
        .valid_in  (dv_valid[fmp_pkg::QUO_WIDTH]),
        .state_in  (dv_state[fmp_pkg::QUO_WIDTH]),
        .valid_out (bl_valid),
        .res_out   (bl_res)
    );

    // ---------------------------------------------------------------- output + skid
    // when en is high the skid is empty, so a result leaving the pipeline
    // lands in the output register or, if that one is stalled, in the skid
    always_comb begin
        out_free        = !out_valid_reg || m_tready;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (out_free) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else begin
            if (out_free) begin
                out_valid_next = bl_valid;
                out_next       = bl_res;
            end else if (bl_valid) begin
                skid_valid_next = 1'b1;
                skid_next       = bl_res;
            end
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg     <= fmp_pkg::WEIGHT_ONE;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            r_valid_reg    <= 1'b0;
            n_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            weight_reg     <= weight_next;
            a_valid_reg    <= a_valid_next;
            b_valid_reg    <= b_valid_next;
            c_valid_reg    <= c_valid_next;
            r_valid_reg    <= r_valid_next;
            n_valid_reg    <= n_valid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg    <= a_side_next;
            b_sq_re_reg   <= b_sq_re_next;
            b_sq_im_reg   <= b_sq_im_next;
            b_side_reg    <= a_side_reg;
            c_state_reg   <= c_state_next;
            r_mag_reg     <= r_mag_next;
            r_prod_re_reg <= r_prod_re_next;
            r_prod_im_reg <= r_prod_im_next;
            r_side_reg    <= sq_last.side;
            n_state_reg   <= n_state_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = fmp_pkg::M_TDATA_WIDTH'({out_reg.im, out_reg.re});
    assign m_tuser  = out_reg.zero;
    assign m_tlast  = out_reg.last;

    // ---------------------------------------------------------------- checks
    // the skid only fills behind a stalled output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    // a waiting skid result moves on as soon as the output is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_tready |=> !skid_valid_reg)
        else $error("skid not drained after output transfer");

    // the stored weight never exceeds one
    assert property (@(posedge aclk) disable iff (!aresetn)
        weight_reg <= fmp_pkg::WEIGHT_ONE)
        else $error("blend weight above one");

    // a zero sample projects onto the real axis, so its imaginary part is zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.zero |-> out_reg.im == '0)
        else $error("zero-magnitude result has a nonzero imaginary part");

endmodule
